// ===== src/blsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_pkg
// Shared widths, constants, register indexes and interface structs for the
// battery level smoother.
// ----------------------------------------------------------------------------
package blsm_pkg;

  // Field widths
  localparam int RAW_W   = 12;
  localparam int FS_W    = 12;
  localparam int RATIO_W = 4;
  localparam int MV_W    = 15;
  localparam int PCT_W   = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV        = 2'd3;

  // Register reset values
  localparam logic [FS_W-1:0]    RST_ADC_FULL_SCALE = 12'd3300;
  localparam logic [RATIO_W-1:0] RST_DIVIDER_RATIO  = 4'd2;
  localparam logic [MV_W-1:0]    RST_EMPTY_MV       = 15'd3000;
  localparam logic [MV_W-1:0]    RST_FULL_MV        = 15'd4200;

  // Converter and voltage constants
  localparam logic [RAW_W-1:0] ADC_MAX_CODE = 12'd4095;
  localparam logic [MV_W-1:0]  MV_MAX       = 15'd32767;
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;

  // Averaging ring
  localparam int WINDOW = 4;
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = MV_W + PTR_W;

  // Shared divider: quotient bits per operation and datapath width
  localparam int AVG_QBITS = MV_W;
  localparam int PCT_QBITS = PCT_W;
  localparam int LVL_NUM_W = MV_W + PCT_W;
  localparam int DIV_W     = (SUM_W > LVL_NUM_W) ? SUM_W : LVL_NUM_W;
  localparam int QUOT_W    = AVG_QBITS;
  localparam int DIV_CNT_W = $clog2(AVG_QBITS + 1);

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [FS_W-1:0]    adc_full_scale_mv;
    logic [RATIO_W-1:0] divider_ratio;
    logic [MV_W-1:0]    empty_mv;
    logic [MV_W-1:0]    full_mv;
  } cfg_t;

  // Request class decided by the front
  typedef enum logic {
    KIND_GOOD = 1'b0,
    KIND_FAIL = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [RAW_W-1:0] raw;
  } entry_t;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     num;
    logic [DIV_W-1:0]     den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/blsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_front
// Holds the configuration registers, accepts input requests and tags each
// one as a good sample or a failed read before it enters the queue.
// ----------------------------------------------------------------------------
module blsm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [blsm_pkg::RAW_W-1:0]       in_raw_sample,
  input  logic                             in_read_failed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output blsm_pkg::cfg_t                   cfg,
  output logic                             push_valid,
  input  logic                             push_ready,
  output blsm_pkg::entry_t                 push_entry
);
  import blsm_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_full_scale_mv <= RST_ADC_FULL_SCALE;
      cfg_r.divider_ratio     <= RST_DIVIDER_RATIO;
      cfg_r.empty_mv          <= RST_EMPTY_MV;
      cfg_r.full_mv           <= RST_FULL_MV;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADC_FULL_SCALE: cfg_r.adc_full_scale_mv <= cfg_data[FS_W-1:0];
        REG_DIVIDER_RATIO:  cfg_r.divider_ratio     <= cfg_data[RATIO_W-1:0];
        REG_EMPTY_MV:       cfg_r.empty_mv          <= cfg_data[MV_W-1:0];
        REG_FULL_MV:        cfg_r.full_mv           <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the request and pass it to the queue
  always_comb begin
    push_entry.kind = in_read_failed ? KIND_FAIL : KIND_GOOD;
    push_entry.raw  = in_raw_sample;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== src/blsm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_queue
// Two-entry queue between front and back so either side can stall alone.
// ----------------------------------------------------------------------------
module blsm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  blsm_pkg::entry_t  push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output blsm_pkg::entry_t  pop_entry
);
  import blsm_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// ===== src/blsm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_div
// Bit-serial restoring divider, one quotient bit per cycle. The caller
// pre-shifts the divisor so the quotient fits in the requested bit count.
// ----------------------------------------------------------------------------
module blsm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  blsm_pkg::div_req_t  req,
  output blsm_pkg::div_rsp_t  rsp
);
  import blsm_pkg::*;

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     den_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 fits;

  assign fits     = (rem_r >= den_r);
  assign rsp.done = run_r && (cnt_r == '0);
  assign rsp.quot = quot_r;

  // Load on start, then resolve one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= req.nbits;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (run_r && (cnt_r != '0)) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      den_r  <= den_r >> 1;
      quot_r <= {quot_r[QUOT_W-2:0], fits};
    end
  end

endmodule

// ===== src/blsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_back
// Carries out one queued request: scale a good sample to millivolts, update the
// sample ring and running sum, average and map to a percentage on the shared
// divider, then hold the result (zeros for a failed read) in the output register.
// ----------------------------------------------------------------------------
module blsm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  blsm_pkg::cfg_t               cfg,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  blsm_pkg::entry_t             pop_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_error,
  output logic [blsm_pkg::MV_W-1:0]    out_average_mv,
  output logic [blsm_pkg::PCT_W-1:0]   out_level_percent
);
  import blsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_STORE,
    S_MEAN_GO,
    S_MEAN,
    S_LEVEL,
    S_LEVEL_RUN,
    S_DONE
  } state_t;

  localparam int PROD_W = RAW_W + FS_W;
  localparam int BATT_W = FS_W + RATIO_W;

  state_t             state_r;
  state_t             state_nxt;

  logic [PROD_W-1:0]  prod_r;
  logic [MV_W-1:0]    batt_r;
  logic [MV_W-1:0]    store_r [WINDOW];
  logic [PTR_W-1:0]   wp_r;
  logic               full_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic               err_r;
  logic [MV_W-1:0]    avg_r;
  logic [PCT_W-1:0]   lvl_r;

  logic               out_valid_r;
  logic               out_error_r;
  logic [MV_W-1:0]    out_avg_r;
  logic [PCT_W-1:0]   out_lvl_r;

  logic [FS_W-1:0]    q_est;
  logic [FS_W:0]      r_est;
  logic [FS_W:0]      pin_mv;
  logic [BATT_W-1:0]  batt_full;
  logic [MV_W-1:0]    batt_sat;
  logic [MV_W-1:0]    old_mv;
  logic [SUM_W-1:0]   sum_nxt;
  logic               wrap;
  logic [CNT_W-1:0]   count_nxt;
  logic               below;
  logic               above;
  logic [MV_W-1:0]    span;
  logic [MV_W-1:0]    excess;
  logic               out_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  blsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE);

  // Divide product by 4095: estimate with a shift, correct by the residue
  always_comb begin
    q_est  = prod_r[PROD_W-1:RAW_W];
    r_est  = {1'b0, prod_r[RAW_W-1:0]} + {1'b0, q_est};
    pin_mv = {1'b0, q_est};
    if (r_est >= {ADC_MAX_CODE, 1'b0}) begin
      pin_mv = {1'b0, q_est} + (FS_W+1)'(2);
    end else if (r_est >= {1'b0, ADC_MAX_CODE}) begin
      pin_mv = {1'b0, q_est} + (FS_W+1)'(1);
    end
    batt_full = pin_mv[FS_W-1:0] * BATT_W'(cfg.divider_ratio);
    batt_sat  = (batt_full > BATT_W'(MV_MAX)) ? MV_MAX : batt_full[MV_W-1:0];
  end

  // Replace the oldest entry in the running sum and count stored samples
  always_comb begin
    old_mv    = store_r[wp_r];
    sum_nxt   = sum_r - SUM_W'(old_mv) + SUM_W'(batt_r);
    wrap      = (wp_r == PTR_W'(WINDOW - 1));
    count_nxt = (full_r || wrap) ? CNT_W'(WINDOW) : CNT_W'(wp_r) + CNT_W'(1);
  end

  // Level classification
  always_comb begin
    below  = (avg_r <= cfg.empty_mv);
    above  = (avg_r >= cfg.full_mv);
    span   = cfg.full_mv - cfg.empty_mv;
    excess = avg_r - cfg.empty_mv;
  end

  // Divider requests: mean first, then the interpolation
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_W'(sum_r);
    div_req.den   = DIV_W'(count_r) << (AVG_QBITS - 1);
    div_req.nbits = DIV_CNT_W'(AVG_QBITS);
    case (state_r)
      S_MEAN_GO: begin
        div_req.start = 1'b1;
      end
      S_LEVEL: begin
        div_req.start = !below && !above;
        div_req.num   = DIV_W'(excess) * DIV_W'(PCT_FULL);
        div_req.den   = DIV_W'(span) << (PCT_QBITS - 1);
        div_req.nbits = DIV_CNT_W'(PCT_QBITS);
      end
      default: ;
    endcase
  end

  // Sequence the steps
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_entry.kind == KIND_FAIL) ? S_DONE : S_SCALE;
        end
      end
      S_SCALE:   state_nxt = S_STORE;
      S_STORE:   state_nxt = S_MEAN_GO;
      S_MEAN_GO: state_nxt = S_MEAN;
      S_MEAN: begin
        if (div_rsp.done) begin
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        state_nxt = (below || above) ? S_DONE : S_LEVEL_RUN;
      end
      S_LEVEL_RUN: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // Drop the result once taken, unless a new one loads this cycle
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            prod_r <= pop_entry.raw * PROD_W'(cfg.adc_full_scale_mv);
            err_r  <= (pop_entry.kind == KIND_FAIL);
            avg_r  <= '0;
            lvl_r  <= '0;
          end
        end
        S_SCALE: begin
          batt_r <= batt_sat;
        end
        S_STORE: begin
          store_r[wp_r] <= batt_r;
          sum_r         <= sum_nxt;
          count_r       <= count_nxt;
          wp_r          <= wrap ? '0 : wp_r + PTR_W'(1);
          if (wrap) begin
            full_r <= 1'b1;
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            avg_r <= div_rsp.quot[MV_W-1:0];
          end
        end
        S_LEVEL: begin
          if (below) begin
            lvl_r <= '0;
          end else if (above) begin
            lvl_r <= PCT_FULL;
          end
        end
        S_LEVEL_RUN: begin
          if (div_rsp.done) begin
            lvl_r <= div_rsp.quot[PCT_W-1:0];
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_error_r <= err_r;
            out_avg_r   <= avg_r;
            out_lvl_r   <= lvl_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_error         = out_error_r;
  assign out_average_mv    = out_avg_r;
  assign out_level_percent = out_lvl_r;

endmodule

// ===== src/battery_level_smoother_core.sv =====
`timescale 1ns / 1ps
// Flow: one request is worked at a time; a failed read goes straight to the result,
//   and a level that clamps skips the level division.
// The shared bit-serial divider resolves 15 quotient bits for the mean and 7 for
//   the level; two more requests wait in the queue.
// Reset: synchronous, active low; clears sample ring, pointer, running sum, queue and
//   output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
// battery_level_smoother_core
// Converter samples to averaged battery millivolts and charge percentage.
// ----------------------------------------------------------------------------
module battery_level_smoother_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [blsm_pkg::RAW_W-1:0]       in_raw_sample,
  input  logic                             in_read_failed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_error,
  output logic [blsm_pkg::MV_W-1:0]        out_average_mv,
  output logic [blsm_pkg::PCT_W-1:0]       out_level_percent,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import blsm_pkg::*;

  cfg_t   cfg;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  blsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_sample  (in_raw_sample),
    .in_read_failed (in_read_failed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cfg            (cfg),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  blsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  blsm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_entry         (pop_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_error         (out_error),
    .out_average_mv    (out_average_mv),
    .out_level_percent (out_level_percent)
  );

endmodule

// ===== src/blsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_checker
// Port-level checks on the result channel of the battery level smoother.
// ----------------------------------------------------------------------------
module blsm_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_error,
  input  logic [blsm_pkg::MV_W-1:0]  out_average_mv,
  input  logic [blsm_pkg::PCT_W-1:0] out_level_percent
);
  import blsm_pkg::*;

  // No result may be shown in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Failed reads carry zero voltage and level
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> (out_average_mv == '0) && (out_level_percent == '0))
    else $error("error result with nonzero fields");

  // Percentage never exceeds full charge
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_percent <= PCT_FULL))
    else $error("level above full");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_mv)
      && $stable(out_level_percent) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind battery_level_smoother_core blsm_checker u_blsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_error         (out_error),
  .out_average_mv    (out_average_mv),
  .out_level_percent (out_level_percent)
);
